>>> hw/rtl/lfh_pkg.sv
// shared constants, types and register codes for the led fire heat block
// no dependencies
`default_nettype none

package lfh_pkg;

   // default geometry of the heat store
   localparam int MAX_RIBBONS_DEF = 32;
   localparam int MAX_CELLS_DEF   = 32;
   localparam int RESULT_CAP      = 32;

   // field widths
   localparam int RIBBON_W = 5;
   localparam int COUNT_W  = 6;
   localparam int CELL_W   = 5;
   localparam int HEAT_W   = 8;

   // register reset values
   localparam logic [7:0]  SPARK_RST = 8'd120;
   localparam logic [7:0]  COOL_RST  = 8'd55;
   localparam logic [15:0] SEED_RST  = 16'd1337;

   // shared multiplier operand widths
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 12;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // random generator s = s*2053 + 13849
   localparam logic [MUL_B_W-1:0] RNG_MUL = 12'd2053;
   localparam logic [15:0]        RNG_INC = 16'd13849;

   // floor(x/3) = (x*683) >> 11 for x below 1024
   localparam logic [MUL_B_W-1:0] DIV3_MUL   = 12'd683;
   localparam int                 DIV3_SHIFT = 11;

   // spark and cooling constants
   localparam logic [MUL_B_W-1:0] SPARK_ROWS = 12'd7;
   localparam logic [MUL_B_W-1:0] SPARK_SPAN = 12'd95;
   localparam logic [8:0]         SPARK_BASE = 9'd160;
   localparam logic [11:0]        COOL_SCALE = 12'd10;
   localparam logic [11:0]        BOUND_ADD  = 12'd2;
   localparam logic [11:0]        BOUND_SAT  = 12'd255;

   // divider widths
   localparam int DIVIDEND_W = 12;
   localparam int DIVISOR_W  = 6;

   typedef enum logic [1:0] {
      REG_SPARK_CHANCE = 2'd0,
      REG_COOLING_RATE = 2'd1,
      REG_RANDOM_SEED  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/lfh_mul.sv
// shared registered multiplier used for random steps, draws and divide by three
// depends on lfh_pkg
`default_nettype none

module lfh_mul (
   input  wire logic                          clock,
   input  wire logic [lfh_pkg::MUL_A_W-1:0]   mul_a,
   input  wire logic [lfh_pkg::MUL_B_W-1:0]   mul_b,
   output logic      [lfh_pkg::MUL_P_W-1:0]   mul_prod
);

   logic [lfh_pkg::MUL_P_W-1:0] prod_ff;
   logic [lfh_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in  = lfh_pkg::MUL_P_W'(mul_a) * lfh_pkg::MUL_P_W'(mul_b);
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/lfh_div.sv
// restoring divider, one quotient bit per cycle
// depends on lfh_pkg
`default_nettype none

module lfh_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lfh_pkg::div_req_type div_req,
   output lfh_pkg::div_rsp_type      div_rsp
);

   localparam int STEP_W = $clog2(lfh_pkg::DIVIDEND_W);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic [lfh_pkg::DIVISOR_W-1:0]    rem_ff, rem_in;
   logic [lfh_pkg::DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [lfh_pkg::DIVISOR_W-1:0]    dsr_ff, dsr_in;
   logic [lfh_pkg::DIVISOR_W:0]      shifted;
   logic [lfh_pkg::DIVISOR_W:0]      diff;

   assign shifted = {rem_ff, quo_ff[lfh_pkg::DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = diff[lfh_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[lfh_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[lfh_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[lfh_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(lfh_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lfh_core.sv
// frame sequencer: heat store, random generator and the cool, drift, spark, emit passes
// depends on lfh_pkg, lfh_mul, lfh_div
`default_nettype none

module lfh_core #(
   parameter int MAX_RIBBONS = lfh_pkg::MAX_RIBBONS_DEF,
   parameter int MAX_CELLS   = lfh_pkg::MAX_CELLS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lfh_pkg::RIBBON_W-1:0]  req_ribbon,
   input  wire logic [lfh_pkg::COUNT_W-1:0]   req_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [lfh_pkg::CELL_W-1:0]    rsp_cell,
   output logic      [lfh_pkg::HEAT_W-1:0]    rsp_heat,
   output logic                               rsp_last,
   input  wire logic [7:0]                    spark_chance,
   input  wire logic [7:0]                    cooling_rate,
   input  wire logic                          seed_load,
   input  wire logic [15:0]                   seed_value
);

   localparam int DEPTH = MAX_RIBBONS * MAX_CELLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CAP   = (MAX_CELLS < lfh_pkg::RESULT_CAP) ? MAX_CELLS : lfh_pkg::RESULT_CAP;
   localparam int CW    = lfh_pkg::COUNT_W;
   localparam int HW    = lfh_pkg::HEAT_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_RMUL, ST_RADD, ST_DMUL, ST_DUSE,
      ST_FRD1, ST_FRD2, ST_FMUL, ST_FWR, ST_ERD, ST_ELD
   } state_type;

   typedef enum logic [1:0] {
      PH_COOL, PH_TEST, PH_SPY, PH_AMT
   } phase_type;

   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   logic [lfh_pkg::RIBBON_W-1:0]  ribbon_ff, ribbon_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [HW-1:0]                 bound_ff, bound_in;
   logic [15:0]                   rng_ff, rng_in;
   logic [2:0]                    y_ff, y_in;
   logic [HW-1:0]                 a_ff, a_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lfh_pkg::CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic [HW-1:0]                 rsp_heat_ff, rsp_heat_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [HW-1:0]                 heat_mem [DEPTH];
   logic [HW-1:0]                 mem_rdata_ff;
   logic                          mem_we, mem_re;
   logic [AW-1:0]                 mem_waddr, mem_raddr;
   logic [HW-1:0]                 mem_wdata;

   logic [lfh_pkg::MUL_A_W-1:0]   mul_a;
   logic [lfh_pkg::MUL_B_W-1:0]   mul_b;
   logic [lfh_pkg::MUL_P_W-1:0]   mul_prod;
   lfh_pkg::div_req_type          div_req;
   lfh_pkg::div_rsp_type          div_rsp;

   logic [CW-1:0]                 count_sat;
   logic [HW-1:0]                 rng_byte;
   logic [HW-1:0]                 draw;
   logic [CW-1:0]                 idx_next;
   logic [9:0]                    drift_sum;
   logic [8:0]                    spark_sum;

   function automatic logic [AW-1:0] cell_addr(input logic [lfh_pkg::RIBBON_W-1:0] ribbon,
                                               input logic [CW-1:0] pos);
      logic [AW:0] base;
      base = (AW+1)'(ribbon) * (AW+1)'(MAX_CELLS);
      return AW'(base + (AW+1)'(pos));
   endfunction

   lfh_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   lfh_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign count_sat = (req_count > CW'(CAP)) ? CW'(CAP) : req_count;
   assign rng_byte  = rng_ff[7:0] + rng_ff[15:8];
   assign draw      = mul_prod[15:8];
   assign idx_next  = idx_ff + 1'b1;
   assign drift_sum = {2'b00, a_ff} + {1'b0, mem_rdata_ff, 1'b0};
   assign spark_sum = {1'b0, mem_rdata_ff} + lfh_pkg::SPARK_BASE + {1'b0, draw};

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      ribbon_in    = ribbon_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      bound_in     = bound_ff;
      rng_in       = rng_ff;
      y_in         = y_ff;
      a_in         = a_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_heat_in  = rsp_heat_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = '0;
      mul_a        = '0;
      mul_b        = '0;
      div_req.start    = 1'b0;
      div_req.dividend = lfh_pkg::DIVIDEND_W'(cooling_rate) * lfh_pkg::COOL_SCALE;
      div_req.divisor  = count_sat;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // zero the whole heat store after reset
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ribbon_in = req_ribbon;
               cnt_in    = count_sat;
               if ((9'(req_ribbon) < 9'(MAX_RIBBONS)) && (req_count != '0)) begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > (lfh_pkg::BOUND_SAT - lfh_pkg::BOUND_ADD)) begin
                  bound_in = HW'(lfh_pkg::BOUND_SAT);
               end else begin
                  bound_in = HW'(div_rsp.quotient + lfh_pkg::BOUND_ADD);
               end
               idx_in   = '0;
               phase_in = PH_COOL;
               state_in = ST_RMUL;
            end
         end
         ST_RMUL: begin
            mul_a    = rng_ff;
            mul_b    = lfh_pkg::RNG_MUL;
            state_in = ST_RADD;
         end
         ST_RADD: begin
            rng_in   = mul_prod[15:0] + lfh_pkg::RNG_INC;
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            mul_a = lfh_pkg::MUL_A_W'(rng_byte);
            unique case (phase_ff)
               PH_COOL: begin
                  mul_b     = lfh_pkg::MUL_B_W'(bound_ff);
                  mem_re    = 1'b1;
                  mem_raddr = cell_addr(ribbon_ff, idx_ff);
                  state_in  = ST_DUSE;
               end
               PH_TEST: begin
                  if (rng_byte < spark_chance) begin
                     phase_in = PH_SPY;
                     state_in = ST_RMUL;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_ERD;
                  end
               end
               PH_SPY: begin
                  mul_b    = lfh_pkg::SPARK_ROWS;
                  state_in = ST_DUSE;
               end
               PH_AMT: begin
                  mul_b     = lfh_pkg::SPARK_SPAN;
                  mem_re    = 1'b1;
                  mem_raddr = cell_addr(ribbon_ff, CW'(y_ff));
                  state_in  = ST_DUSE;
               end
            endcase
         end
         ST_DUSE: begin
            unique case (phase_ff)
               PH_COOL: begin
                  // saturating subtract of the cooling draw
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(ribbon_ff, idx_ff);
                  mem_wdata = (mem_rdata_ff > draw) ? (mem_rdata_ff - draw) : '0;
                  idx_in    = idx_next;
                  state_in  = ST_RMUL;
                  if (idx_next == cnt_ff) begin
                     if (cnt_ff >= CW'(3)) begin
                        idx_in   = cnt_ff - 1'b1;
                        state_in = ST_FRD1;
                     end else begin
                        phase_in = PH_TEST;
                     end
                  end
               end
               PH_SPY: begin
                  y_in     = draw[2:0];
                  phase_in = PH_AMT;
                  state_in = ST_RMUL;
               end
               PH_AMT: begin
                  // saturating add of the spark
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(ribbon_ff, CW'(y_ff));
                  mem_wdata = spark_sum[8] ? {HW{1'b1}} : spark_sum[HW-1:0];
                  idx_in    = '0;
                  state_in  = ST_ERD;
               end
               PH_TEST: begin
                  idx_in   = '0;
                  state_in = ST_ERD;
               end
            endcase
         end
         ST_FRD1: begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(ribbon_ff, idx_ff - CW'(1));
            state_in  = ST_FRD2;
         end
         ST_FRD2: begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(ribbon_ff, idx_ff - CW'(2));
            a_in      = mem_rdata_ff;
            state_in  = ST_FMUL;
         end
         ST_FMUL: begin
            mul_a    = lfh_pkg::MUL_A_W'(drift_sum);
            mul_b    = lfh_pkg::DIV3_MUL;
            state_in = ST_FWR;
         end
         ST_FWR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(ribbon_ff, idx_ff);
            mem_wdata = mul_prod[lfh_pkg::DIV3_SHIFT +: HW];
            if (idx_ff == CW'(2)) begin
               phase_in = PH_TEST;
               state_in = ST_RMUL;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_FRD1;
            end
         end
         ST_ERD: begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(ribbon_ff, idx_ff);
            state_in  = ST_ELD;
         end
         ST_ELD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = idx_ff[lfh_pkg::CELL_W-1:0];
               rsp_heat_in  = mem_rdata_ff;
               rsp_last_in  = (idx_next == cnt_ff);
               idx_in       = idx_next;
               state_in     = (idx_next == cnt_ff) ? ST_IDLE : ST_ERD;
            end
         end
      endcase

      if (seed_load) begin
         rng_in = seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_COOL;
         clr_ff       <= '0;
         rng_ff       <= lfh_pkg::SEED_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         rng_ff       <= rng_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ribbon_ff   <= ribbon_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      bound_ff    <= bound_in;
      y_ff        <= y_in;
      a_ff        <= a_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_heat_ff <= rsp_heat_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heat_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= heat_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell  = rsp_cell_ff;
   assign rsp_heat  = rsp_heat_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/led_fire_heat_simulation.sv
// led fire heat simulation: one item advances one ribbon's heat row by a frame, then
// streams out every cell; items with zero count or an out-of-range ribbon are dropped
// an item runs in order: accept, divide, cool each cell, drift each cell above the second,
// test for a spark and add one on a strike, then emit each cell; one item at a time
// after reset a clearing pass zeroes the store before any item
`default_nettype none

module led_fire_heat_simulation #(
   parameter int MAX_RIBBONS = lfh_pkg::MAX_RIBBONS_DEF,
   parameter int MAX_CELLS   = lfh_pkg::MAX_CELLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // item input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,     // [4:0] ribbon_index, [10:5] cell_count

   // result stream, one item per cell
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,     // [4:0] cell_index, [12:5] heat_value
   output logic             rsp_tlast,     // last_cell

   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic [7:0]              spark_ff, spark_in;
   logic [7:0]              cool_ff, cool_in;
   logic [15:0]             seed_ff, seed_in;
   logic                    csr_wr;
   lfh_pkg::reg_index_type  csr_index;
   logic                    seed_load;
   logic [lfh_pkg::CELL_W-1:0] rsp_cell;
   logic [lfh_pkg::HEAT_W-1:0] rsp_heat;

   // register file, written in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = lfh_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      spark_in   = spark_ff;
      cool_in    = cool_ff;
      seed_in    = seed_ff;
      seed_load  = 1'b0;
      csr_prdata = '0;
      unique case (csr_index)
         lfh_pkg::REG_SPARK_CHANCE: begin
            csr_prdata = {24'd0, spark_ff};
            if (csr_wr) begin
               spark_in = csr_pwdata[7:0];
            end
         end
         lfh_pkg::REG_COOLING_RATE: begin
            csr_prdata = {24'd0, cool_ff};
            if (csr_wr) begin
               cool_in = csr_pwdata[7:0];
            end
         end
         lfh_pkg::REG_RANDOM_SEED: begin
            csr_prdata = {16'd0, seed_ff};
            if (csr_wr) begin
               seed_in   = csr_pwdata[15:0];
               seed_load = 1'b1;   // reload the generator too
            end
         end
         default: begin
            csr_prdata = '0;       // unmapped address reads zero, writes dropped
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spark_ff <= lfh_pkg::SPARK_RST;
         cool_ff  <= lfh_pkg::COOL_RST;
         seed_ff  <= lfh_pkg::SEED_RST;
      end else begin
         spark_ff <= spark_in;
         cool_ff  <= cool_in;
         seed_ff  <= seed_in;
      end
   end

   // frame engine with its own output register
   lfh_core #(
      .MAX_RIBBONS (MAX_RIBBONS),
      .MAX_CELLS   (MAX_CELLS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_ribbon   (req_tdata[4:0]),
      .req_count    (req_tdata[10:5]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_cell     (rsp_cell),
      .rsp_heat     (rsp_heat),
      .rsp_last     (rsp_tlast),
      .spark_chance (spark_ff),
      .cooling_rate (cool_ff),
      .seed_load    (seed_load),
      .seed_value   (csr_pwdata[15:0])
   );

   assign rsp_tdata = {3'd0, rsp_heat, rsp_cell};

endmodule

`default_nettype wire

>>> sim/lfh_heat_checker.sv
// checker for the led fire heat block: watches the item, result and register channels,
// predicts each ribbon frame and compares every cell result in order
// depends on lfh_pkg for field widths, register codes and reset values
module lfh_heat_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,     // [4:0] ribbon_index, [10:5] cell_count
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,     // [4:0] cell_index, [12:5] heat_value
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failure_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RIBBONS = lfh_pkg::MAX_RIBBONS_DEF;
   localparam int CELLS   = lfh_pkg::MAX_CELLS_DEF;
   localparam int CW      = lfh_pkg::CELL_W;
   localparam int HW      = lfh_pkg::HEAT_W;
   localparam int RW      = lfh_pkg::RIBBON_W;
   localparam int NW      = lfh_pkg::COUNT_W;

   typedef struct packed {
      logic [CW-1:0] pos;
      logic [HW-1:0] heat;
      logic          last;
   } cell_heat_type;

   logic [HW-1:0]     heat_rows [RIBBONS][CELLS];
   logic [15:0]       rng_state;
   logic [7:0]        spark_level;
   logic [7:0]        cool_level;
   cell_heat_type     expected_cells [$];
   int                mismatches;

   function automatic logic [7:0] next_random_byte();
      rng_state = rng_state * 16'd2053 + 16'd13849;
      return rng_state[7:0] + rng_state[15:8];
   endfunction

   // scaled draw: (byte * limit) >> 8
   function automatic logic [7:0] random_below(input logic [7:0] limit);
      logic [15:0] product;
      product = next_random_byte() * limit;
      return product[15:8];
   endfunction

   task automatic report_mismatch(input cell_heat_type want, input logic [CW-1:0] got_cell,
                                  input logic [HW-1:0] got_heat, input logic got_last);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch: expected cell %0d heat %0d last %0b, got cell %0d heat %0d last %0b",
                  want.pos, want.heat, want.last, got_cell, got_heat, got_last);
   endtask

   // one frame of one ribbon, then queue the new heat of each emitted cell
   task automatic advance_ribbon(input logic [RW-1:0] ribbon,
                                 input logic [NW-1:0] count_field);
      int            cells;
      int            bound;
      int            sum;
      logic [7:0]    loss;
      logic [7:0]    row;
      logic [7:0]    boost;
      cell_heat_type item;
      cells = count_field;
      if (cells == 0) return;        // empty ribbon: no draws, no results
      if (cells > CELLS) cells = CELLS;
      bound = int'(cool_level) * 10 / cells + 2;
      if (bound > 255) bound = 255;
      for (int i = 0; i < cells; i++) begin
         loss = random_below(bound[7:0]);
         heat_rows[ribbon][i] = (heat_rows[ribbon][i] > loss) ?
                                heat_rows[ribbon][i] - loss : 8'd0;
      end
      for (int k = cells - 1; k >= 2; k--)
         heat_rows[ribbon][k] = 8'((int'(heat_rows[ribbon][k-1]) +
                                    2 * int'(heat_rows[ribbon][k-2])) / 3);
      if (next_random_byte() < spark_level) begin
         row   = random_below(8'd7);
         boost = 8'd160 + random_below(8'd95);
         sum   = int'(heat_rows[ribbon][row]) + int'(boost);
         heat_rows[ribbon][row] = (sum > 255) ? 8'd255 : 8'(sum);
      end
      for (int i = 0; i < cells; i++) begin
         item.pos  = CW'(i);
         item.heat = heat_rows[ribbon][i];
         item.last = (i == cells - 1);
         expected_cells.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      cell_heat_type          want;
      logic [CW-1:0]          got_cell;
      logic [HW-1:0]          got_heat;
      lfh_pkg::reg_index_type which;
      if (reset) begin
         foreach (heat_rows[r, c]) heat_rows[r][c] = '0;
         spark_level = lfh_pkg::SPARK_RST;
         cool_level  = lfh_pkg::COOL_RST;
         rng_state   = lfh_pkg::SEED_RST;
         expected_cells.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            which = lfh_pkg::reg_index_type'(csr_paddr[3:2]);
            case (which)
               lfh_pkg::REG_SPARK_CHANCE: spark_level = csr_pwdata[7:0];
               lfh_pkg::REG_COOLING_RATE: cool_level  = csr_pwdata[7:0];
               lfh_pkg::REG_RANDOM_SEED:  rng_state   = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            advance_ribbon(req_tdata[RW-1:0], req_tdata[RW+NW-1:RW]);
         if (rsp_tvalid && rsp_tready) begin
            got_cell = rsp_tdata[CW-1:0];
            got_heat = rsp_tdata[CW+HW-1:CW];
            if (expected_cells.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected cell item: cell %0d heat %0d last %0b",
                           got_cell, got_heat, rsp_tlast);
            end else begin
               want = expected_cells.pop_front();
               if (got_cell !== want.pos || got_heat !== want.heat ||
                   rsp_tlast !== want.last)
                  report_mismatch(want, got_cell, got_heat, rsp_tlast);
            end
         end
      end
      failure_count <= mismatches;
      pending_count <= expected_cells.size();
   end

endmodule

>>> sim/led_fire_heat_simulation_test.sv
// top of the led fire heat testbench: clock, reset, item and register stimulus, verdict
// depends on lfh_pkg, the led_fire_heat_simulation block and lfh_heat_checker
module led_fire_heat_simulation_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         HOLD_CYCLES   = 300;   // long result back-pressure
   localparam int         SETTLE_CYCLES = 400;   // longer than one full 32-cell frame
   localparam int         QUIET_LIMIT   = 8000;  // covers the store clearing pass too
   localparam logic [3:0] UNUSED_ADDR   = 4'd12; // first address past the register list
   localparam int         RW            = lfh_pkg::RIBBON_W;
   localparam int         NW            = lfh_pkg::COUNT_W;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [4:0] ribbon_index, [10:5] cell_count
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [4:0] cell_index, [12:5] heat_value
   logic        rsp_tlast;    // last_cell
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int pending;
   int quiet_cycles = 0;
   int hold_asked   = 0;   // bumped by the stimulus, served by the receiver
   bit gaps_on      = 1'b1;

   always #5 clock = ~clock;

   led_fire_heat_simulation u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lfh_heat_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .failure_count (failures),
      .pending_count (pending)
   );

   // watchdog: cycles in a row with no item moving on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // result receiver: random stalls, plus one long hold-off when asked
   initial begin : receiver
      int stall;
      int holds_served;
      holds_served = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_served < hold_asked) begin
            // block fills up behind this and stops taking items
            holds_served++;
            stall = HOLD_CYCLES;
         end else begin
            stall = gaps_on ? int'($urandom_range(0, 8)) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [3:0] reg_addr(input lfh_pkg::reg_index_type which);
      return {which, 2'b00};
   endfunction

   // setup phase, access phase, then an idle gap so writes never run together
   task automatic write_csr(input logic [3:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_fire(input logic [7:0] spark, input logic [7:0] cool,
                           input logic [15:0] seed);
      write_csr(reg_addr(lfh_pkg::REG_SPARK_CHANCE), {24'd0, spark});
      write_csr(reg_addr(lfh_pkg::REG_COOLING_RATE), {24'd0, cool});
      write_csr(reg_addr(lfh_pkg::REG_RANDOM_SEED), {16'd0, seed});
   endtask

   // offer one ribbon frame; valid stays high straight into the next item on a zero gap
   task automatic send_frame(input logic [RW-1:0] ribbon,
                             input logic [NW-1:0] count);
      int gap;
      gap = gaps_on ? int'($urandom_range(0, 8)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {5'd0, count, ribbon};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly short ribbons over a few rows so heat builds up, some long, some odd counts
   task automatic send_random_frame();
      logic [RW-1:0] ribbon;
      logic [NW-1:0] count;
      int            pick;
      ribbon = $urandom_range(0, 1) ? RW'($urandom_range(0, 3)) : RW'($urandom_range(0, 31));
      pick   = int'($urandom_range(0, 99));
      if (pick < 5)       count = '0;
      else if (pick < 10) count = NW'($urandom_range(33, 63));
      else if (pick < 70) count = NW'($urandom_range(1, 8));
      else                count = NW'($urandom_range(9, 32));
      send_frame(ribbon, count);
   endtask

   // stop offering, wait for every expected cell, then let the block go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, empty and oversize ribbons
      send_frame(5'd0, 6'd1);
      send_frame(5'd0, 6'd2);
      send_frame(5'd0, 6'd3);
      send_frame(5'd0, 6'd6);
      send_frame(5'd0, 6'd7);
      send_frame(5'd0, 6'd32);
      send_frame(5'd31, 6'd32);
      send_frame(5'd31, 6'd63);   // saturates to 32 cells
      send_frame(5'd21, 6'd0);    // empty ribbon, no draws and no cells
      send_frame(5'd10, 6'd33);
      send_frame(5'd10, 6'd0);
      send_frame(5'd17, 6'd1);
      settle();

      // sparks on all but the top random byte, on short ribbons: hits above the top stay in the row
      set_fire(8'd255, 8'd0, 16'd0);
      write_csr(UNUSED_ADDR, 32'hFFFF_FFFF);  // past the register list, ignored
      send_frame(5'd3, 6'd2);
      send_frame(5'd3, 6'd2);
      send_frame(5'd3, 6'd4);
      send_frame(5'd3, 6'd1);
      send_frame(5'd3, 6'd7);
      send_frame(5'd3, 6'd32);
      settle();

      // heavy cooling with no sparks, seed at its top
      set_fire(8'd0, 8'd255, 16'hFFFF);
      send_frame(5'd3, 6'd1);
      send_frame(5'd3, 6'd32);
      send_frame(5'd31, 6'd16);
      send_frame(5'd0, 6'd10);
      settle();

      // random phases, each under its own settings; phase 1 runs without gaps
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0)
            set_fire(lfh_pkg::SPARK_RST, lfh_pkg::COOL_RST, lfh_pkg::SEED_RST);
         else
            set_fire(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)));
         gaps_on = (phase != 1);
         repeat (20) send_random_frame();
         settle();
      end

      // back-pressure: receiver holds off while full-length frames keep coming
      gaps_on = 1'b0;
      hold_asked++;
      repeat (10) send_frame(RW'($urandom_range(0, 31)), 6'd32);
      gaps_on = 1'b1;
      repeat (10) send_random_frame();
      settle();

      if (failures == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> led_fire_heat_simulation.f
hw/rtl/lfh_pkg.sv
hw/rtl/lfh_mul.sv
hw/rtl/lfh_div.sv
hw/rtl/lfh_core.sv
hw/rtl/led_fire_heat_simulation.sv
sim/lfh_heat_checker.sv
sim/led_fire_heat_simulation_test.sv
